// File: design/bdpt_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bdpt_pkg
// Shared types and constants for the button debounce and press timer.
// ---------------------------------------------------------------------------
package bdpt_pkg;

  localparam int unsigned COUNT_W = 8;
  localparam int unsigned PHASE_W = 10;
  localparam int unsigned DSEC_W  = 8;
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned APB_AW  = 3;

  localparam logic [COUNT_W-1:0] DEBOUNCE_TICKS_RST = 8'd10;
  localparam logic [PHASE_W-1:0] TICKS_PER_DSEC_RST = 10'd100;

  // Register index, taken from paddr[2]
  localparam logic REG_DEBOUNCE_TICKS = 1'b0;
  localparam logic REG_TICKS_PER_DSEC = 1'b1;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_RELEASED = 2'd1,
    EV_PRESSED  = 2'd2
  } event_t;

endpackage : bdpt_pkg
`default_nettype wire

// File: design/button_debounce_press_timer_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// button_debounce_press_timer_unit
// Integrating debounce of an active-low button with a decisecond press timer.
// ---------------------------------------------------------------------------
// Each input item is one millisecond tick carrying the raw pin level
// (0 = pressed). An integrating counter rises while the sample disagrees with
// the debounced state and decays while it agrees; on reaching debounce_ticks
// the state flips and a change event is reported. A modulo-256 decisecond
// clock, advanced every ticks_per_decisecond items, timestamps each press, so
// every result carries the held time and, on the release item, the last held
// duration. Exactly one result per item. An item passes an input register and
// then the state update, which writes the result register. One item is
// taken every cycle while the result channel does not stall. Registers:
// debounce_ticks at 0x0 (reset 10), ticks_per_decisecond at 0x4 (reset 100);
// write them only while idle.
module button_debounce_press_timer_unit
  import bdpt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // tick channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_button_level,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             out_change_event,
  output logic                   out_is_pressed,
  output logic [DSEC_W-1:0]      out_held_decisec,
  output logic [DSEC_W-1:0]      out_release_decisec,
  // configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  // configuration registers
  logic [COUNT_W-1:0] debounce_ticks_r;
  logic [PHASE_W-1:0] ticks_per_dsec_r;

  // input stage
  logic s1_valid_r;
  logic s1_level_r;

  // block state
  logic [COUNT_W-1:0] bounce_count_r, bounce_count_nxt;
  logic               deb_level_r, deb_level_nxt;
  logic [PHASE_W-1:0] tick_phase_r, tick_phase_nxt;
  logic [DSEC_W-1:0]  dsec_clock_r, dsec_clock_nxt;
  logic [DSEC_W-1:0]  press_start_r, press_start_nxt;
  logic [DSEC_W-1:0]  last_held_r, last_held_nxt;

  // result register
  logic               out_valid_r;
  event_t             event_r, event_nxt;
  logic               pressed_r;
  logic [DSEC_W-1:0]  held_r, held_nxt;
  logic [DSEC_W-1:0]  release_r, release_nxt;

  logic s1_advance;
  logic cfg_write;

  logic               sample;
  logic [COUNT_W-1:0] thresh;
  logic [COUNT_W-1:0] count_step;
  logic [DSEC_W-1:0]  held_raw;
  logic [PHASE_W:0]   phase_inc;

  assign s1_advance = s1_valid_r && !(out_valid_r && out_stall);
  assign in_stall   = s1_valid_r && !s1_advance;
  assign cfg_write  = psel && penable && pwrite && pready;
  assign pready     = 1'b1;

  always_comb begin
    unique case (paddr[2])
      REG_DEBOUNCE_TICKS: prdata = {{(APB_DW-COUNT_W){1'b0}}, debounce_ticks_r};
      REG_TICKS_PER_DSEC: prdata = {{(APB_DW-PHASE_W){1'b0}}, ticks_per_dsec_r};
      default:            prdata = '0;
    endcase
  end

  // per-tick update
  always_comb begin
    sample           = ~s1_level_r;
    thresh           = (debounce_ticks_r == '0) ? COUNT_W'(1) : debounce_ticks_r;
    deb_level_nxt    = deb_level_r;
    press_start_nxt  = press_start_r;
    event_nxt        = EV_NONE;
    held_nxt         = '0;
    release_nxt      = '0;

    if (sample == deb_level_r) begin
      count_step = (bounce_count_r != '0) ? bounce_count_r - COUNT_W'(1) : '0;
    end else begin
      count_step = (bounce_count_r != '1) ? bounce_count_r + COUNT_W'(1) : bounce_count_r;
    end

    bounce_count_nxt = count_step;
    if (count_step >= thresh) begin
      bounce_count_nxt = '0;
      if (sample != deb_level_r) begin
        deb_level_nxt = sample;
        event_nxt     = sample ? EV_PRESSED : EV_RELEASED;
        // stamp one decisecond back so the press item reports 1
        if (sample) begin
          press_start_nxt = dsec_clock_r - DSEC_W'(1);
        end
      end
    end

    held_raw = dsec_clock_r - press_start_nxt;
    if (deb_level_nxt) begin
      held_nxt = (held_raw == '0) ? DSEC_W'(1) : held_raw;
    end

    if (held_nxt == '0 && last_held_r != '0) begin
      release_nxt   = last_held_r;
      last_held_nxt = '0;
    end else begin
      last_held_nxt = held_nxt;
    end

    phase_inc = {1'b0, tick_phase_r} + (PHASE_W+1)'(1);
    if (phase_inc >= {1'b0, ticks_per_dsec_r}) begin
      tick_phase_nxt = '0;
      dsec_clock_nxt = dsec_clock_r + DSEC_W'(1);
    end else begin
      tick_phase_nxt = phase_inc[PHASE_W-1:0];
      dsec_clock_nxt = dsec_clock_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ticks_r <= DEBOUNCE_TICKS_RST;
      ticks_per_dsec_r <= TICKS_PER_DSEC_RST;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_DEBOUNCE_TICKS: debounce_ticks_r <= pwdata[COUNT_W-1:0];
        REG_TICKS_PER_DSEC: ticks_per_dsec_r <= pwdata[PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      bounce_count_r <= '0;
      deb_level_r    <= 1'b0;
      tick_phase_r   <= '0;
      dsec_clock_r   <= '0;
      press_start_r  <= '0;
      last_held_r    <= '0;
    end else begin
      // take a new item whenever the input stage frees up
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (s1_advance) begin
        out_valid_r    <= 1'b1;
        bounce_count_r <= bounce_count_nxt;
        deb_level_r    <= deb_level_nxt;
        tick_phase_r   <= tick_phase_nxt;
        dsec_clock_r   <= dsec_clock_nxt;
        press_start_r  <= press_start_nxt;
        last_held_r    <= last_held_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_level_r <= in_button_level;
    end
    if (s1_advance) begin
      event_r   <= event_nxt;
      pressed_r <= deb_level_nxt;
      held_r    <= held_nxt;
      release_r <= release_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_change_event    = event_r;
  assign out_is_pressed      = pressed_r;
  assign out_held_decisec    = held_r;
  assign out_release_decisec = release_r;

endmodule : button_debounce_press_timer_unit
`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the button debounce and press timer unit.
// ---------------------------------------------------------------------------
// Millisecond tick items carrying a raw button level are queued phase by
// phase and driven through a valid/stall driver with random idle bursts.
// A debounce and press-timer model runs on every accepted tick, and a monitor
// compares each result, field by field, against the oldest prediction while
// stalling the result channel at random. Both registers are rewritten over
// the APB-style port between phases, while the unit is idle.
module tb_top;
  import bdpt_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    event_t             ev;
    logic               pressed;
    logic [DSEC_W-1:0]  held;
    logic [DSEC_W-1:0]  released;
  } button_report_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_button_level = 1'b1;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          out_change_event;
  logic                out_is_pressed;
  logic [DSEC_W-1:0]   out_held_decisec;
  logic [DSEC_W-1:0]   out_release_decisec;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  // pending tick levels and predicted reports
  logic                tick_queue[$];
  button_report_t      pending_reports[$];

  // register copies and debounce/timer state
  logic [COUNT_W-1:0]  debounce_cfg = DEBOUNCE_TICKS_RST;
  logic [PHASE_W-1:0]  divider_cfg = TICKS_PER_DSEC_RST;
  logic [COUNT_W-1:0]  bounce_cnt = '0;
  logic                deb_pressed = 1'b0;
  logic [PHASE_W-1:0]  tick_phase = '0;
  logic [DSEC_W-1:0]   dsec_clock = '0;
  logic [DSEC_W-1:0]   press_start = '0;
  logic [DSEC_W-1:0]   last_held = '0;

  int                  fail_count = 0;
  int                  ticks_accepted = 0;
  int                  reports_checked = 0;
  int                  press_events = 0;
  int                  release_events = 0;
  int                  cycle_count = 0;
  int                  send_gap = 0;
  int                  recv_gap = 0;
  bit                  calm = 1'b0;

  button_debounce_press_timer_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_button_level     (in_button_level),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_change_event    (out_change_event),
    .out_is_pressed      (out_is_pressed),
    .out_held_decisec    (out_held_decisec),
    .out_release_decisec (out_release_decisec),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s: got %0d, want %0d (report %0d)", what, got, want,
             reports_checked);
    fail_count++;
  endtask

  // One millisecond tick of the debouncer and press timer.
  task automatic debounce_tick(input logic level);
    logic               sample;
    logic [COUNT_W-1:0] thresh;
    button_report_t     r;
    sample = ~level;
    thresh = (debounce_cfg == '0) ? COUNT_W'(1) : debounce_cfg;
    r = '{ev: EV_NONE, pressed: 1'b0, held: '0, released: '0};
    if (sample == deb_pressed) begin
      if (bounce_cnt != '0) bounce_cnt--;
    end else if (bounce_cnt != '1) begin
      bounce_cnt++;
    end
    if (bounce_cnt >= thresh) begin
      bounce_cnt = '0;
      if (sample != deb_pressed) begin
        deb_pressed = sample;
        r.ev = sample ? EV_PRESSED : EV_RELEASED;
        // back-date the press so its own tick reads one decisecond
        if (sample) press_start = dsec_clock - DSEC_W'(1);
      end
    end
    if (deb_pressed) begin
      r.held = dsec_clock - press_start;
      if (r.held == '0) r.held = DSEC_W'(1);
    end
    if (r.held == '0 && last_held != '0) begin
      r.released = last_held;
      last_held = '0;
    end else begin
      last_held = r.held;
    end
    if (int'(tick_phase) + 1 >= int'(divider_cfg)) begin
      tick_phase = '0;
      dsec_clock = dsec_clock + DSEC_W'(1);
    end else begin
      tick_phase++;
    end
    r.pressed = deb_pressed;
    pending_reports.push_back(r);
  endtask

  // Driver: present queued ticks, with random idle bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        debounce_tick(in_button_level);
        ticks_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (tick_queue.size() != 0) begin
          if (!calm && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            send_gap <= $urandom_range(0, 12);
          end else begin
            in_valid <= 1'b1;
            in_button_level <= tick_queue.pop_front();
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result, stall in random bursts.
  always @(posedge clk) begin
    button_report_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_reports.size() == 0) begin
          report_mismatch("result with nothing expected", out_held_decisec, -1);
        end else begin
          want = pending_reports.pop_front();
          if (out_change_event !== want.ev)
            report_mismatch("change_event", out_change_event, want.ev);
          if (out_is_pressed !== want.pressed)
            report_mismatch("is_pressed", out_is_pressed, want.pressed);
          if (out_held_decisec !== want.held)
            report_mismatch("held_decisec", out_held_decisec, want.held);
          if (out_release_decisec !== want.released)
            report_mismatch("release_decisec", out_release_decisec, want.released);
          if (want.ev == EV_PRESSED) press_events++;
          if (want.ev == EV_RELEASED) release_events++;
        end
        reports_checked++;
      end
      if (recv_gap > 0) begin
        out_stall <= 1'b1;
        recv_gap <= recv_gap - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        recv_gap <= $urandom_range(0, 12);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports outstanding", cycle_count,
               pending_reports.size());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic cfg_write(input logic reg_idx, input logic [APB_DW-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_idx == REG_DEBOUNCE_TICKS) debounce_cfg = value[COUNT_W-1:0];
    else divider_cfg = value[PHASE_W-1:0];
  endtask

  task automatic queue_ticks(input logic level, input int n);
    repeat (n) tick_queue.push_back(level);
  endtask

  // Drain: nothing queued, nothing on the wire, nothing outstanding.
  task automatic wait_idle();
    do @(negedge clk);
    while (tick_queue.size() != 0 || in_valid || pending_reports.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Noise, then a run at one level: long enough to flip it, or now and
  // then a broken run that may fall short.
  task automatic queue_episode(input int thresh, input bit long_hold, inout int n);
    int   noise;
    int   run;
    logic level;
    noise = $urandom_range(0, 4);
    for (int i = 0; i < noise; i++) tick_queue.push_back(1'($urandom_range(0, 1)));
    level = long_hold ? 1'b0 : 1'($urandom_range(0, 1));
    if (long_hold) run = 260;
    else if ($urandom_range(0, 4) == 0) run = $urandom_range(1, thresh);
    else run = thresh + $urandom_range(0, 6);
    queue_ticks(level, run);
    n += noise + run;
  endtask

  initial begin
    int                  random_ticks;
    int                  phase;
    int                  episodes;
    int                  thresh;
    bit                  last_phase;
    logic [APB_DW-1:0]   db_word;
    logic [APB_DW-1:0]   div_word;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: press settles on the tenth tick
    queue_ticks(1'b0, 11);
    wait_idle();
    // zero threshold and divider act as one: release, press, hold, release
    cfg_write(REG_DEBOUNCE_TICKS, '0);
    cfg_write(REG_TICKS_PER_DSEC, '0);
    queue_ticks(1'b1, 1);
    queue_ticks(1'b0, 3);
    queue_ticks(1'b1, 2);
    wait_idle();
    // leave the counter and the phase part way up
    cfg_write(REG_DEBOUNCE_TICKS, 32'd20);
    cfg_write(REG_TICKS_PER_DSEC, 32'd1023);
    queue_ticks(1'b0, 5);
    wait_idle();
    // lower both below the running counts
    cfg_write(REG_DEBOUNCE_TICKS, 32'd3);
    cfg_write(REG_TICKS_PER_DSEC, 32'd2);
    queue_ticks(1'b1, 1);
    queue_ticks(1'b0, 1);
    queue_ticks(1'b1, 1);
    wait_idle();

    random_ticks = 0;
    phase = 0;
    last_phase = 1'b0;
    while (!last_phase) begin
      db_word = $urandom();
      div_word = $urandom();
      // close with a calm long hold that runs the held time past 255
      last_phase = (random_ticks >= 300);
      if (last_phase) begin
        db_word[COUNT_W-1:0] = 8'd1;
        div_word[PHASE_W-1:0] = 10'd1;
      end else begin
        case (phase)
          0: begin
            db_word[COUNT_W-1:0] = 8'd255;
            div_word[PHASE_W-1:0] = 10'd1023;
          end
          1: begin
            db_word[COUNT_W-1:0] = 8'd1;
            div_word[PHASE_W-1:0] = 10'd1;
          end
          2: begin
            db_word[COUNT_W-1:0] = 8'd0;
            div_word[PHASE_W-1:0] = 10'd0;
          end
          default: begin
            db_word[COUNT_W-1:0] = ($urandom_range(0, 5) == 0) ?
                                   COUNT_W'($urandom_range(9, 40)) :
                                   COUNT_W'($urandom_range(1, 8));
            div_word[PHASE_W-1:0] = ($urandom_range(0, 5) == 0) ?
                                    PHASE_W'($urandom_range(21, 1023)) :
                                    PHASE_W'($urandom_range(1, 20));
          end
        endcase
      end
      cfg_write(REG_DEBOUNCE_TICKS, db_word);
      cfg_write(REG_TICKS_PER_DSEC, div_word);
      thresh = (db_word[COUNT_W-1:0] == '0) ? 1 : int'(db_word[COUNT_W-1:0]);
      calm = last_phase;
      episodes = (phase == 0) ? 1 : last_phase ? 2 : $urandom_range(3, 8);
      for (int e = 0; e < episodes; e++)
        queue_episode(thresh, last_phase && e == 0, random_ticks);
      wait_idle();
      phase++;
    end

    repeat (10) @(posedge clk);
    $display("%0d ticks over %0d register settings, %0d reports checked",
             ticks_accepted, phase + 4, reports_checked);
    $display("%0d presses and %0d releases debounced, %0d mismatches",
             press_events, release_events, fail_count);
    if (fail_count == 0 && pending_reports.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
